FILE: rtl/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and constants of the periodic trajectory segmenter.
// ----------------------------------------------------------------------------
`default_nettype none

package pts_pkg;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOX_LENGTH    = 2'd0,
    CFG_STEP_LENGTH   = 2'd1,
    CFG_PIXEL_SCALE   = 2'd2,
    CFG_BOUNDARY_MODE = 2'd3
  } cfg_idx_t;

  localparam logic [30:0] BOX_LENGTH_RST  = 31'd65536;
  localparam logic [30:0] STEP_LENGTH_RST = 31'd65536;
  localparam logic [31:0] PIXEL_SCALE_RST = 32'd65536000;

  // 1e-6 in Q.32
  localparam logic [64:0] EPS_SQ = 65'd4295;

  // 1.0 in Q1.30
  localparam logic [61:0] Q30_ONE = 62'd1073741824;

  localparam int DIV_STEPS = 62;

endpackage

`default_nettype wire

FILE: rtl/periodic_trajectory_segmenter_unit.sv
// ----------------------------------------------------------------------------
// periodic_trajectory_segmenter_unit
// Splits one walker step into up to three plot segments in pixel coordinates.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; busy stays high
// until the last segment has been shown. Each segment appears on the out_
// ports for exactly one cycle with out_valid high; the receiver must take it
// then. The crossing time is set by a restoring divider, one quotient bit
// per cycle over 62 bits, run at most once per axis for each crossing; all
// products go through one shared 32x32 multiplier.
`default_nettype none

module periodic_trajectory_segmenter_unit
  import pts_pkg::*;
#(
  parameter int PLOT_SIZE    = 1000,
  parameter int BORDER_WIDTH = 20
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [31:0]   in_old_x,
  input  logic signed [31:0]   in_old_y,
  input  logic signed [31:0]   in_new_x,
  input  logic signed [31:0]   in_new_y,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [31:0]          cfg_wdata,
  output logic                 out_valid,
  output logic signed [15:0]   out_start_px,
  output logic signed [15:0]   out_start_py,
  output logic signed [15:0]   out_end_px,
  output logic signed [15:0]   out_end_py,
  output logic                 out_mark_walker,
  output logic                 out_last
);

  localparam int ORIGIN = BORDER_WIDTH + PLOT_SIZE / 2;
  localparam logic signed [50:0] ORIGIN_Q = 51'(ORIGIN) <<< 32;

  typedef enum logic [3:0] {
    ST_IDLE, ST_WCHK, ST_SQX, ST_SQY, ST_SQS, ST_CMP, ST_UNW, ST_DSET,
    ST_DIV, ST_SEL, ST_AL0, ST_AL1, ST_AL2, ST_PXM, ST_PXS, ST_EMIT
  } state_t;

  state_t state_r;

  logic [30:0]        box_r, step_r;
  logic [31:0]        scale_r;
  logic               mode_r;

  logic signed [31:0] ox_r, oy_r, nx_r, ny_r, cx_r, cy_r;
  logic signed [31:0] seg_ax_r, seg_ay_r, seg_bx_r, seg_by_r;
  logic               fin_r;
  logic [1:0]         n_r, k_r;
  logic [30:0]        ax_r, ay_r;
  logic [64:0]        acc_r;
  logic [63:0]        mul_r;
  logic signed [34:0] dx_r, dy_r;
  logic signed [62:0] tx_r, ty_r;
  logic [61:0]        num_r;
  logic [33:0]        rem_r, dvs_r;
  logic               dneg_r, axis_r;
  logic [5:0]         cnt_r;
  logic signed [31:0] al_o_r;
  logic [30:0]        al_mt_r;
  logic [33:0]        al_md_r;
  logic               al_neg_r, al_y_r;
  logic signed [15:0] pix_r [4];

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  // helpers
  logic [30:0]        h;
  logic signed [32:0] hs;
  logic signed [32:0] dxw, dyw;
  logic [32:0]        dxm, dym;
  logic signed [34:0] ux, uy;
  logic signed [31:0] coord;
  logic [31:0]        coord_mag;
  logic               pneg;
  logic signed [50:0] pv;
  logic signed [18:0] pq;
  logic signed [15:0] pq_sat;
  logic signed [34:0] dd;
  logic signed [31:0] od;
  logic signed [33:0] nn;
  logic [34:0]        rem_sh;
  logic               ge;
  logic [61:0]        quo;
  logic               usex;
  logic [65:0]        al_prod;
  logic signed [36:0] al_p;
  logic signed [37:0] al_sum;
  logic signed [31:0] al_res;
  logic signed [31:0] wx, wy;

  function automatic logic signed [34:0] unwrap_t(
    input logic signed [31:0] o, input logic signed [31:0] n,
    input logic [30:0] s, input logic [30:0] l);
    logic signed [34:0] o35, n35, s35, l35, t35;
    o35 = 35'(o);
    n35 = 35'(n);
    s35 = $signed({4'b0, s});
    l35 = $signed({4'b0, l});
    if (o35 - s35 > n35) t35 = n35 + l35;
    else if (o35 + s35 < n35) t35 = n35 - l35;
    else t35 = n35;
    return t35 - o35;
  endfunction

  function automatic logic signed [31:0] wrap_opp(
    input logic signed [31:0] v, input logic signed [32:0] hv,
    input logic [30:0] l);
    logic signed [32:0] v33, l33, r33;
    v33 = 33'(v);
    l33 = $signed({2'b0, l});
    if (v33 >= hv) r33 = v33 - l33;
    else if (v33 <= -hv) r33 = v33 + l33;
    else r33 = v33;
    return r33[31:0];
  endfunction

  function automatic logic signed [31:0] sel_coord(
    input logic [1:0] k, input logic signed [31:0] a0,
    input logic signed [31:0] a1, input logic signed [31:0] a2,
    input logic signed [31:0] a3);
    logic signed [31:0] r;
    case (k)
      2'd0:    r = a0;
      2'd1:    r = a1;
      2'd2:    r = a2;
      default: r = a3;
    endcase
    return r;
  endfunction

  always_comb begin
    h   = 31'((33'(box_r) + 33'd1) >> 1);
    hs  = $signed({2'b0, h});
    dxw = 33'(nx_r) - 33'(ox_r);
    dyw = 33'(ny_r) - 33'(oy_r);
    dxm = dxw[32] ? 33'(-dxw) : 33'(dxw);
    dym = dyw[32] ? 33'(-dyw) : 33'(dyw);
    ux  = unwrap_t(ox_r, nx_r, step_r, box_r);
    uy  = unwrap_t(oy_r, ny_r, step_r, box_r);

    coord     = sel_coord(k_r, seg_ax_r, seg_ay_r, seg_bx_r, seg_by_r);
    coord_mag = coord[31] ? 32'(-33'(coord)) : 32'(coord);
    pneg      = coord[31] ^ k_r[0];
    pv        = ORIGIN_Q + (pneg ? -$signed({2'b0, mul_r[48:0]})
                                 :  $signed({2'b0, mul_r[48:0]}));
    pq        = pv[50:32];
    if (pv[50] && (pv[31:0] != 32'd0)) pq = pq + 19'sd1;
    if (|mul_r[63:49]) pq_sat = pneg ? -16'sd32768 : 16'sd32767;
    else if (pq > 19'sd32767) pq_sat = 16'sd32767;
    else if (pq < -19'sd32768) pq_sat = -16'sd32768;
    else pq_sat = pq[15:0];

    dd = axis_r ? dy_r : dx_r;
    od = axis_r ? oy_r : ox_r;
    nn = (dd > 35'sd0) ? 34'(hs) - 34'(od) : 34'(od) + 34'(hs);

    rem_sh = {rem_r, num_r[61]};
    ge     = rem_sh >= {1'b0, dvs_r};
    quo    = {num_r[60:0], ge};

    usex = (dx_r != 35'sd0) && ((dy_r == 35'sd0) || (tx_r <= ty_r));

    al_prod = 66'(acc_r) + {mul_r[33:0], 32'b0};
    al_p    = al_neg_r ? -$signed({1'b0, al_prod[65:30]})
                       :  $signed({1'b0, al_prod[65:30]});
    al_sum  = 38'(al_o_r) + 38'(al_p);
    if (al_sum > 38'sd2147483647) al_res = 32'sh7FFFFFFF;
    else if (al_sum < -38'sd2147483648) al_res = 32'sh80000000;
    else al_res = al_sum[31:0];

    wx = wrap_opp(cx_r, hs, box_r);
    wy = wrap_opp(cy_r, hs, box_r);

    case (state_r)
      ST_SQX:  begin mul_a = {1'b0, ax_r};    mul_b = {1'b0, ax_r};      end
      ST_SQY:  begin mul_a = {1'b0, ay_r};    mul_b = {1'b0, ay_r};      end
      ST_SQS:  begin mul_a = {1'b0, step_r};  mul_b = {1'b0, step_r};    end
      ST_AL0:  begin mul_a = {1'b0, al_mt_r}; mul_b = al_md_r[31:0];     end
      ST_AL1:  begin mul_a = {1'b0, al_mt_r}; mul_b = {30'b0, al_md_r[33:32]}; end
      ST_PXM:  begin mul_a = coord_mag;       mul_b = scale_r;           end
      default: begin mul_a = 32'd0;           mul_b = 32'd0;             end
    endcase
    mul_p = 64'(mul_a) * 64'(mul_b);
  end

  always_ff @(posedge clk) begin
    mul_r <= mul_p;
    if (!rst_n) begin
      state_r <= ST_IDLE;
      box_r   <= BOX_LENGTH_RST;
      step_r  <= STEP_LENGTH_RST;
      scale_r <= PIXEL_SCALE_RST;
      mode_r  <= 1'b0;
      n_r     <= 2'd0;
      k_r     <= 2'd0;
      fin_r   <= 1'b0;
      axis_r  <= 1'b0;
      cnt_r   <= 6'd0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_addr))
          CFG_BOX_LENGTH:    box_r   <= cfg_wdata[30:0];
          CFG_STEP_LENGTH:   step_r  <= cfg_wdata[30:0];
          CFG_PIXEL_SCALE:   scale_r <= cfg_wdata;
          CFG_BOUNDARY_MODE: mode_r  <= cfg_wdata[0];
          default: ;
        endcase
      end
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            ox_r <= in_old_x;
            oy_r <= in_old_y;
            nx_r <= in_new_x;
            ny_r <= in_new_y;
            n_r  <= 2'd0;
            if (!mode_r) begin
              seg_ax_r <= in_old_x;
              seg_ay_r <= in_old_y;
              seg_bx_r <= in_new_x;
              seg_by_r <= in_new_y;
              fin_r    <= 1'b1;
              k_r      <= 2'd0;
              state_r  <= ST_PXM;
            end else begin
              state_r <= ST_WCHK;
            end
          end
        end
        ST_WCHK: begin
          ax_r <= dxm[30:0];
          ay_r <= dym[30:0];
          if (n_r == 2'd2) begin
            seg_ax_r <= ox_r;
            seg_ay_r <= oy_r;
            seg_bx_r <= nx_r;
            seg_by_r <= ny_r;
            fin_r    <= 1'b1;
            k_r      <= 2'd0;
            state_r  <= ST_PXM;
          end else if ((dxm[32:31] != 2'b0) || (dym[32:31] != 2'b0)) begin
            state_r <= ST_UNW;
          end else begin
            state_r <= ST_SQX;
          end
        end
        ST_SQX: state_r <= ST_SQY;
        ST_SQY: begin
          acc_r   <= 65'(mul_r);
          state_r <= ST_SQS;
        end
        ST_SQS: begin
          acc_r   <= acc_r + 65'(mul_r);
          state_r <= ST_CMP;
        end
        ST_CMP: begin
          if (acc_r > 65'(mul_r) + EPS_SQ) begin
            state_r <= ST_UNW;
          end else begin
            seg_ax_r <= ox_r;
            seg_ay_r <= oy_r;
            seg_bx_r <= nx_r;
            seg_by_r <= ny_r;
            fin_r    <= 1'b1;
            k_r      <= 2'd0;
            state_r  <= ST_PXM;
          end
        end
        ST_UNW: begin
          dx_r    <= ux;
          dy_r    <= uy;
          axis_r  <= 1'b0;
          state_r <= ST_DSET;
        end
        ST_DSET: begin
          if (dd == 35'sd0) begin
            if (axis_r) begin
              ty_r    <= 63'sd0;
              state_r <= ST_SEL;
            end else begin
              tx_r   <= 63'sd0;
              axis_r <= 1'b1;
            end
          end else begin
            num_r   <= {(nn[33] ? 32'(-nn) : 32'(nn)), 30'b0};
            rem_r   <= 34'd0;
            dvs_r   <= dd[34] ? 34'(-dd) : 34'(dd);
            dneg_r  <= nn[33];
            cnt_r   <= 6'd0;
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_r <= ge ? 34'(rem_sh - {1'b0, dvs_r}) : rem_sh[33:0];
          num_r <= quo;
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'(DIV_STEPS - 1)) begin
            if (axis_r) begin
              ty_r    <= dneg_r ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
              state_r <= ST_SEL;
            end else begin
              tx_r    <= dneg_r ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
              axis_r  <= 1'b1;
              state_r <= ST_DSET;
            end
          end
        end
        ST_SEL: begin
          if (usex) begin
            cx_r     <= (dx_r > 35'sd0) ? 32'(hs) : 32'(-hs);
            al_o_r   <= oy_r;
            al_mt_r  <= (62'(tx_r[62] ? -tx_r : tx_r) > Q30_ONE) ? 31'(Q30_ONE)
                        : 31'(tx_r[62] ? -tx_r : tx_r);
            al_md_r  <= dy_r[34] ? 34'(-dy_r) : 34'(dy_r);
            al_neg_r <= tx_r[62] ^ dy_r[34];
            al_y_r   <= 1'b1;
            state_r  <= ST_AL0;
          end else if (dy_r != 35'sd0) begin
            cy_r     <= (dy_r > 35'sd0) ? 32'(hs) : 32'(-hs);
            al_o_r   <= ox_r;
            al_mt_r  <= (62'(ty_r[62] ? -ty_r : ty_r) > Q30_ONE) ? 31'(Q30_ONE)
                        : 31'(ty_r[62] ? -ty_r : ty_r);
            al_md_r  <= dx_r[34] ? 34'(-dx_r) : 34'(dx_r);
            al_neg_r <= ty_r[62] ^ dx_r[34];
            al_y_r   <= 1'b0;
            state_r  <= ST_AL0;
          end else begin
            cx_r     <= ox_r;
            cy_r     <= oy_r;
            seg_ax_r <= ox_r;
            seg_ay_r <= oy_r;
            seg_bx_r <= ox_r;
            seg_by_r <= oy_r;
            fin_r    <= 1'b0;
            k_r      <= 2'd0;
            state_r  <= ST_PXM;
          end
        end
        ST_AL0: state_r <= ST_AL1;
        ST_AL1: begin
          acc_r   <= 65'(mul_r);
          state_r <= ST_AL2;
        end
        ST_AL2: begin
          seg_ax_r <= ox_r;
          seg_ay_r <= oy_r;
          if (al_y_r) begin
            cy_r     <= al_res;
            seg_bx_r <= cx_r;
            seg_by_r <= al_res;
          end else begin
            cx_r     <= al_res;
            seg_bx_r <= al_res;
            seg_by_r <= cy_r;
          end
          fin_r   <= 1'b0;
          k_r     <= 2'd0;
          state_r <= ST_PXM;
        end
        ST_PXM: state_r <= ST_PXS;
        ST_PXS: begin
          pix_r[k_r] <= pq_sat;
          k_r        <= k_r + 2'd1;
          state_r    <= (k_r == 2'd3) ? ST_EMIT : ST_PXM;
        end
        ST_EMIT: begin
          if (fin_r) begin
            state_r <= ST_IDLE;
          end else begin
            ox_r    <= wx;
            oy_r    <= wy;
            n_r     <= n_r + 2'd1;
            state_r <= ST_WCHK;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = (state_r == ST_EMIT);
  assign out_start_px    = pix_r[0];
  assign out_start_py    = pix_r[1];
  assign out_end_px      = pix_r[2];
  assign out_end_py      = pix_r[3];
  assign out_mark_walker = fin_r;
  assign out_last        = fin_r;

`ifndef SYNTHESIS
  a_strobe_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");
  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");
  a_more_segs: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> busy)
    else $error("block idle before final segment");
  a_seg_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && n_r == 2'd2) |-> fin_r)
    else $error("third segment not marked final");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for periodic_trajectory_segmenter_unit.
// A queue of walker steps feeds a clocked driver; a clocked monitor compares
// every plotted segment with segments predicted in the bench, in open and
// periodic modes over several box, step and scale settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb
  import pts_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ORIGIN = 20 + 1000 / 2;
  localparam longint TWO31 = 64'sd2147483648;
  localparam longint QONE = 64'sd1073741824;

  typedef struct packed {
    logic signed [31:0] ox, oy, nx, ny;
  } step_t;

  typedef struct packed {
    logic signed [15:0] spx, spy, epx, epy;
    logic mark, fin;
  } seg_t;

  logic clk = 0, rst_n = 0, start = 0, busy;
  logic signed [31:0] in_old_x = 0, in_old_y = 0, in_new_x = 0, in_new_y = 0;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_addr = CFG_BOX_LENGTH;
  logic [31:0] cfg_wdata = 0;
  logic out_valid, out_mark_walker, out_last;
  logic signed [15:0] out_start_px, out_start_py, out_end_px, out_end_py;

  periodic_trajectory_segmenter_unit uut (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  longint box_len = 65536, step_len = 65536, px_scale = 65536000, periodic = 0;
  step_t pending_steps[$];
  seg_t expected_segs[$];
  int errors = 0;
  int idle_pct = 11;
  logic hold = 0;

  function automatic longint sat32(longint v);
    if (v >= TWO31) return TWO31 - 1;
    if (v < -TWO31) return -TWO31;
    return v;
  endfunction

  function automatic longint absv(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [15:0] pixel(longint c, bit flip);
    bit neg;
    logic [63:0] prod;
    longint v, q;
    neg = (c < 0) != flip;
    prod = absv(c) * px_scale;
    if (prod >= 64'd1 << 49) return neg ? -16'sd32768 : 16'sd32767;
    v = ORIGIN * (2 * TWO31) + (neg ? -longint'(prod) : longint'(prod));
    q = v / (2 * TWO31);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic seg_t segment(longint ax, ay, bx, by, bit f);
    seg_t s;
    s.spx = pixel(ax, 0); s.spy = pixel(ay, 1);
    s.epx = pixel(bx, 0); s.epy = pixel(by, 1);
    s.mark = f; s.fin = f;
    return s;
  endfunction

  function automatic bit jumped(longint ox, oy, nx, ny);
    logic [63:0] ax, ay;
    ax = absv(nx - ox); ay = absv(ny - oy);
    if (ax >= TWO31 || ay >= TWO31) return 1;
    return ax * ax + ay * ay > step_len * step_len + 64'd4295;
  endfunction

  function automatic longint unwrap_axis(longint o, n);
    if (o - step_len > n) return n + box_len;
    if (o + step_len < n) return n - box_len;
    return n;
  endfunction

  function automatic longint hit_time(longint o, d, h);
    if (d > 0) return (h - o) * QONE / d;
    return (o + h) * QONE / (-d);
  endfunction

  function automatic longint slide(longint o, t, d);
    longint p;
    if (t > QONE) t = QONE;
    if (t < -QONE) t = -QONE;
    p = longint'((64'(absv(t)) * 64'(absv(d))) >> 30);
    if ((t < 0) != (d < 0)) p = -p;
    return sat32(o + p);
  endfunction

  function automatic longint fold(longint v, h);
    if (v >= h) return v - box_len;
    if (v <= -h) return v + box_len;
    return v;
  endfunction

  task automatic predict_segments(step_t s);
    longint ox, oy, nx, ny, h, dx, dy, cx, cy, tx, ty;
    int n;
    ox = s.ox; oy = s.oy; nx = s.nx; ny = s.ny;
    h = (box_len + 1) / 2;
    n = 0;
    if (periodic != 0) begin
      while (n < 2 && jumped(ox, oy, nx, ny)) begin
        dx = unwrap_axis(ox, nx) - ox;
        dy = unwrap_axis(oy, ny) - oy;
        cx = ox; cy = oy; tx = 0; ty = 0;
        if (dx != 0) tx = hit_time(ox, dx, h);
        if (dy != 0) ty = hit_time(oy, dy, h);
        if (dx != 0 && (dy == 0 || tx <= ty)) begin
          cx = dx > 0 ? h : -h;
          cy = slide(oy, tx, dy);
        end else if (dy != 0) begin
          cy = dy > 0 ? h : -h;
          cx = slide(ox, ty, dx);
        end
        expected_segs.push_back(segment(ox, oy, cx, cy, 0));
        n++;
        ox = fold(cx, h);
        oy = fold(cy, h);
      end
    end
    expected_segs.push_back(segment(ox, oy, nx, ny, 1));
  endtask

  // driver
  always @(posedge clk) begin
    if (start && !busy) begin
      predict_segments({in_old_x, in_old_y, in_new_x, in_new_y});
    end
    if (start && busy) begin
      // hold
    end else if (rst_n && !hold && pending_steps.size() > 0 &&
                 $urandom_range(99, 0) >= idle_pct) begin
      step_t s;
      s = pending_steps.pop_front();
      start <= 1;
      in_old_x <= s.ox; in_old_y <= s.oy; in_new_x <= s.nx; in_new_y <= s.ny;
    end else begin
      start <= 0;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      seg_t got, want;
      got = {out_start_px, out_start_py, out_end_px, out_end_py,
             out_mark_walker, out_last};
      if (expected_segs.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected segment %h", got);
      end else begin
        want = expected_segs.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("segment mismatch: expected %h got %h", want, got);
        end
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, longint val);
    @(posedge clk);
    cfg_we <= 1; cfg_addr <= idx; cfg_wdata <= val[31:0];
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      CFG_BOX_LENGTH: box_len = val & 64'h7FFFFFFF;
      CFG_STEP_LENGTH: step_len = val & 64'h7FFFFFFF;
      CFG_PIXEL_SCALE: px_scale = val & 64'hFFFFFFFF;
      default: periodic = val & 1;
    endcase
  endtask

  task automatic drain;
    while (pending_steps.size() > 0 || start || busy || expected_segs.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rnd_pos(longint h);
    if (h <= 1) return $urandom;
    return $urandom_range(2 * h - 2, 0) - (h - 1);
  endfunction

  task automatic add_walk(int cnt);
    longint h, px, py, nx, ny, sl;
    step_t s;
    h = (box_len + 1) / 2;
    px = rnd_pos(h); py = rnd_pos(h);
    for (int i = 0; i < cnt; i++) begin
      if ($urandom_range(9, 0) == 0) begin
        s = {$urandom, $urandom, $urandom, $urandom};
      end else begin
        sl = step_len;
        nx = px + longint'($urandom_range(2 * sl, 0)) - sl;
        ny = py + longint'($urandom_range(2 * sl, 0)) - sl;
        nx = fold(nx, h); ny = fold(ny, h);
        s.ox = px; s.oy = py; s.nx = nx; s.ny = ny;
        px = nx; py = ny;
      end
      pending_steps.push_back(s);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1;
    // open mode, field extremes
    pending_steps.push_back({32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF});
    pending_steps.push_back({32'sd0, 32'sd0, 32'sd0, 32'sd0});
    pending_steps.push_back({32'hFFFFFFFF, 32'h5555AAAA, 32'hAAAA5555, 32'd1});
    drain();
    write_reg(CFG_BOUNDARY_MODE, 1);
    pending_steps.push_back({32'sd0, 32'sd0, 32'sd0, 32'sd0});
    pending_steps.push_back({32'sd30000, 32'sd0, -32'sd30000, 32'sd0});
    pending_steps.push_back({32'sd0, 32'sd30000, 32'sd0, -32'sd30000});
    pending_steps.push_back({32'sd30000, 32'sd30000, -32'sd30000, -32'sd30000});
    pending_steps.push_back({-32'sd30000, 32'sd20000, 32'sd30000, -32'sd25000});
    pending_steps.push_back({32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF});
    pending_steps.push_back({32'sd100, 32'sd100, 32'sd100, 32'sd100});
    drain();
    write_reg(CFG_STEP_LENGTH, 0);
    pending_steps.push_back({32'sd100, 32'sd0, 32'sd100, 32'sd0});
    pending_steps.push_back({32'sd100, 32'sd0, 32'sd200, 32'sd5});
    drain();
    write_reg(CFG_BOX_LENGTH, 0);
    write_reg(CFG_PIXEL_SCALE, 0);
    pending_steps.push_back({32'sd100, 32'sd50, -32'sd100, 32'sd7});
    pending_steps.push_back({32'sd1, 32'sd1, 32'sd1, 32'sd1});
    drain();
    write_reg(CFG_BOX_LENGTH, 32'h7FFFFFFF);
    write_reg(CFG_STEP_LENGTH, 32'h7FFFFFFF);
    write_reg(CFG_PIXEL_SCALE, 32'hFFFFFFFF);
    pending_steps.push_back({32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF});
    pending_steps.push_back({32'sd5, -32'sd5, -32'sd9, 32'sd9});
    drain();
    // random walks
    for (int ph = 0; ph < 6; ph++) begin
      idle_pct = ph < 2 ? 11 : (ph < 4 ? 53 : 0);
      write_reg(CFG_BOX_LENGTH, ph == 5 ? 1 : $urandom_range(32'h40000, 32'h4000));
      write_reg(CFG_STEP_LENGTH, $urandom_range(box_len / 4 + 1, 0));
      write_reg(CFG_PIXEL_SCALE, ph == 1 ? 32'hFFFFFFFF : $urandom_range(32'h4000000, 0));
      write_reg(CFG_BOUNDARY_MODE, ph != 3);
      add_walk(38);
      drain();
      hold = 1;
      add_walk(38);
      hold = 0;
      drain();
    end
    if (errors == 0 && expected_segs.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
